/* rtl/bracket_tree_arity_checker_unit_defines.svh */
// Assertion macros shared by the bracket tree arity checker RTL.
// Included by the modules that carry concurrent assertions.
`ifndef BRACKET_TREE_ARITY_CHECKER_UNIT_DEFINES_SVH
`define BRACKET_TREE_ARITY_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BTAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define BTAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* rtl/btac_pkg.sv */
// Package for the bracket tree arity checker: types, character codes, status codes.
// No dependencies.
`default_nettype none

package btac_pkg;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [1:0] ST_BINARY     = 2'd0;
    localparam logic [1:0] ST_NOT_BINARY = 2'd1;
    localparam logic [1:0] ST_MALFORMED  = 2'd2;

    localparam logic [1:0] COUNT_MAX    = 2'd3;
    localparam logic [1:0] BINARY_LIMIT = 2'd2;

    typedef logic [1:0] count_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic inc;
    } cell_op_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } result_t;

endpackage

`default_nettype wire

/* rtl/btac_cell.sv */
// Letter-count stack cell: holds one count, shifts on push and pop, counts up on inc.
// Depends on btac_pkg.
`default_nettype none

module btac_cell
    import btac_pkg::*;
(
    input  wire           clk,
    input  wire cell_op_t op,
    input  wire count_t   prev_count,
    input  wire count_t   next_count,
    output count_t        count
);

    count_t count_reg;

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            count_reg <= prev_count;
        end
        else if (op.pop)
        begin
            count_reg <= next_count;
        end
        else if (op.inc)
        begin
            count_reg <= (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 2'd1;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

/* rtl/btac_ctrl.sv */
// Byte decoder with stack level and flags; issues cell operations and the end status.
// Depends on btac_pkg and the assertion macro header.
`default_nettype none
`include "bracket_tree_arity_checker_unit_defines.svh"

module btac_ctrl
    import btac_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         accept,
    input  wire [7:0]   symbol,
    input  wire         has_symbol,
    input  wire         last,
    input  wire count_t top_count,
    output cell_op_t    op,
    output result_t     result
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

    logic [LVL_W-1:0] level_reg, level_next;
    logic             err_reg, err_next;
    logic             nb_reg, nb_next;
    logic             any_reg, any_next;

    logic is_blank, is_letter;

    assign is_blank  = (symbol == CH_SPACE) || (symbol == CH_NEWLINE);
    assign is_letter = ((symbol >= CH_UPPER_A) && (symbol <= CH_UPPER_Z)) ||
                       ((symbol >= CH_LOWER_A) && (symbol <= CH_LOWER_Z));

    always_comb
    begin
        op            = '0;
        result        = '0;
        result.status = ST_BINARY;
        level_next    = level_reg;
        err_next      = err_reg;
        nb_next       = nb_reg;
        any_next      = any_reg;
        if (accept)
        begin
            if (has_symbol && !is_blank)
            begin
                any_next = 1'b1;
                if (!err_reg)
                begin
                    if (symbol == CH_OPEN)
                    begin
                        if (level_reg == LVL_FULL)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            op.push    = 1'b1;
                            level_next = level_reg + 1'b1;
                        end
                    end
                    else if (symbol == CH_CLOSE)
                    begin
                        if (level_reg == '0)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            op.pop     = 1'b1;
                            level_next = level_reg - 1'b1;
                        end
                    end
                    else if (is_letter)
                    begin
                        if (level_reg == '0)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            op.inc = 1'b1;
                            if (top_count >= BINARY_LIMIT)
                            begin
                                nb_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            if (last)
            begin
                result.valid = 1'b1;
                if (err_next || !any_next || (level_next != '0))
                begin
                    result.status = ST_MALFORMED;
                end
                else if (nb_next)
                begin
                    result.status = ST_NOT_BINARY;
                end
                else
                begin
                    result.status = ST_BINARY;
                end
                level_next = '0;
                err_next   = 1'b0;
                nb_next    = 1'b0;
                any_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            err_reg   <= 1'b0;
            nb_reg    <= 1'b0;
            any_reg   <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            err_reg   <= err_next;
            nb_reg    <= nb_next;
            any_reg   <= any_next;
        end
    end

    `BTAC_ASSERT_IMP(a_one_op, clk, rst_n, 1'b1, $onehot0({op.push, op.pop, op.inc}))
    `BTAC_ASSERT_IMP(a_level_range, clk, rst_n, 1'b1, level_reg <= LVL_FULL)
    `BTAC_ASSERT_IMP(a_inc_nonempty, clk, rst_n, op.inc || op.pop, level_reg != '0)
    `BTAC_ASSERT_NXT(a_end_clears, clk, rst_n, accept && last,
                     (level_reg == '0) && !err_reg && !nb_reg && !any_reg)

endmodule

`default_nettype wire

/* rtl/bracket_tree_arity_checker_unit.sv */
// Top level of the bracket tree arity checker: cell chain, control and output buffer.
// Depends on btac_pkg, btac_cell, btac_ctrl and the assertion macro header.
//
//   channel | signals                              | direction
//   input   | in_valid, in_ready, symbol,          | in
//           | has_symbol, last                     |
//   output  | out_valid, out_ready, status         | out
//
// One byte per cycle while in_ready is high; each accepted byte updates the stack.
// A final status is registered as output, or in the skid while the output is held.
// A two-entry output buffer keeps input flowing while one status waits to be taken.
// Reset clears level, flags and buffer at once; the cell chain needs no clearing.
`default_nettype none
`include "bracket_tree_arity_checker_unit_defines.svh"

module bracket_tree_arity_checker_unit
    import btac_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  wire       clk,
    input  wire       rst_n,
    input  wire       in_valid,
    output logic      in_ready,
    input  wire [7:0] symbol,
    input  wire       has_symbol,
    input  wire       last,
    output logic      out_valid,
    input  wire       out_ready,
    output logic [1:0] status
);

    logic     accept;
    cell_op_t op;
    result_t  result;
    count_t   counts [STACK_DEPTH];
    cell_op_t cell_ops [STACK_DEPTH];

    logic       out_valid_reg, skid_valid_reg;
    logic [1:0] out_status_reg, skid_status_reg;
    logic       drain;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    btac_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .symbol     (symbol),
        .has_symbol (has_symbol),
        .last       (last),
        .top_count  (counts[0]),
        .op         (op),
        .result     (result)
    );

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        count_t prev_c, next_c;

        always_comb
        begin
            cell_ops[i]      = op;
            cell_ops[i].inc  = (i == 0) ? op.inc : 1'b0;
        end

        if (i == 0)
        begin : g_first
            assign prev_c = '0;
        end
        else
        begin : g_mid
            assign prev_c = counts[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_end
            assign next_c = counts[i];
        end
        else
        begin : g_inner
            assign next_c = counts[i+1];
        end

        btac_cell u_cell (
            .clk        (clk),
            .op         (cell_ops[i]),
            .prev_count (prev_c),
            .next_count (next_c),
            .count      (counts[i])
        );
    end

    assign drain = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (drain)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (result.valid)
        begin
            if (out_valid_reg && !drain)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (drain)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (drain)
            begin
                out_status_reg <= skid_status_reg;
            end
        end
        else if (result.valid)
        begin
            if (out_valid_reg && !drain)
            begin
                skid_status_reg <= result.status;
            end
            else
            begin
                out_status_reg <= result.status;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;

    `BTAC_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `BTAC_ASSERT_NXT(a_stall_fills_skid, clk, rst_n,
                     result.valid && out_valid_reg && !out_ready, skid_valid_reg)
    `BTAC_ASSERT_NXT(a_result_shown, clk, rst_n, result.valid, out_valid_reg)

endmodule

`default_nettype wire

/* tb/sv/bracket_tree_arity_checker_unit_tb.sv */
// Self-checking bench for the bracket tree arity checker: queued byte transactions, random
// idling on both channels and a behavioural tree predictor checked against every status.
// Depends on btac_pkg and the bracket_tree_arity_checker_unit RTL.
module bracket_tree_arity_checker_unit_tb;
    import btac_pkg::*;

    localparam int TREE_DEPTH = 64;
    localparam int RUN_ITEMS  = 1650;

    typedef struct {
        logic [7:0] sym;
        logic       has;
        logic       fin;
    } text_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] symbol = 8'h00;
    logic       has_symbol = 1'b0;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status;

    text_byte_t text_queue[$];
    text_byte_t next_byte;
    logic [1:0] status_due[$];
    logic [1:0] want_status;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         byte_count = 0;
    int         mismatch_count = 0;

    count_t     group_letters[TREE_DEPTH];
    int         open_groups = 0;
    logic       tree_error = 1'b0;
    logic       tree_wide = 1'b0;
    logic       tree_nonblank = 1'b0;

    bracket_tree_arity_checker_unit #(.STACK_DEPTH(TREE_DEPTH)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .symbol     (symbol),
        .has_symbol (has_symbol),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic predict_transaction(logic [7:0] c, logic has, logic fin);
        logic is_letter;
        is_letter = (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
        if (has && c != CH_SPACE && c != CH_NEWLINE)
        begin
            tree_nonblank = 1'b1;
            if (!tree_error)
            begin
                if (c == CH_OPEN)
                begin
                    if (open_groups >= TREE_DEPTH)
                        tree_error = 1'b1;
                    else
                    begin
                        group_letters[open_groups] = '0;
                        open_groups++;
                    end
                end
                else if (c == CH_CLOSE)
                begin
                    if (open_groups == 0)
                        tree_error = 1'b1;
                    else
                        open_groups--;
                end
                else if (is_letter)
                begin
                    if (open_groups == 0)
                        tree_error = 1'b1;
                    else
                    begin
                        if (group_letters[open_groups - 1] != COUNT_MAX)
                            group_letters[open_groups - 1]++;
                        if (group_letters[open_groups - 1] > BINARY_LIMIT)
                            tree_wide = 1'b1;
                    end
                end
                else
                    tree_error = 1'b1;
            end
        end
        if (fin)
        begin
            if (tree_error || !tree_nonblank || open_groups != 0)
                status_due.push_back(ST_MALFORMED);
            else if (tree_wide)
                status_due.push_back(ST_NOT_BINARY);
            else
                status_due.push_back(ST_BINARY);
            open_groups   = 0;
            tree_error    = 1'b0;
            tree_wide     = 1'b0;
            tree_nonblank = 1'b0;
        end
    endtask

    // Driver: advance to the next queued byte once the current transaction is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            symbol     <= 8'h00;
            has_symbol <= 1'b0;
            last       <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_transaction(symbol, has_symbol, last);
            if (!in_valid || in_ready)
            begin
                if (text_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_byte  = text_queue.pop_front();
                    in_valid   <= 1'b1;
                    symbol     <= next_byte.sym;
                    has_symbol <= next_byte.has;
                    last       <= next_byte.fin;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each status taken against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (status_due.size() == 0)
                    report_mismatch($sformatf("unexpected status %0d", status));
                else
                begin
                    want_status = status_due.pop_front();
                    if (status !== want_status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  status, want_status));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_byte(logic [7:0] c, logic has, logic fin);
        text_byte_t b;
        b.sym = c;
        b.has = has;
        b.fin = fin;
        text_queue.push_back(b);
        if (has)
            byte_count++;
    endtask

    task automatic send_bytes(logic [7:0] txt[$], bit end_on_byte);
        for (int i = 0; i < txt.size(); i++)
        begin
            if ($urandom_range(0, 24) == 0)
                push_byte(8'($urandom), 1'b0, 1'b0);
            push_byte(txt[i], 1'b1, end_on_byte && i == txt.size() - 1);
        end
        if (!end_on_byte || txt.size() == 0)
            push_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic send_string(string s, bit end_on_byte);
        logic [7:0] txt[$];
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
        send_bytes(txt, end_on_byte);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) != 0)
            return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
        return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
    endfunction

    function automatic logic [7:0] rand_blank();
        return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_NEWLINE;
    endfunction

    task automatic gen_tree_text();
        logic [7:0] txt[$];
        int         letters[$];
        int         steps;
        int         fault;
        int         r;
        int         depth;
        steps = $urandom_range(1, 20);
        fault = $urandom_range(0, 11);
        if ($urandom_range(0, 39) == 0)
        begin
            // nest to one below, at, or one past the stack limit
            depth = $urandom_range(TREE_DEPTH - 1, TREE_DEPTH + 1);
            repeat (depth) txt.push_back(CH_OPEN);
            repeat ($urandom_range(0, 3)) txt.push_back(rand_letter());
            repeat (depth) txt.push_back(CH_CLOSE);
        end
        else if ($urandom_range(0, 29) == 0)
        begin
            repeat ($urandom_range(0, 3)) txt.push_back(rand_blank());
        end
        else
        begin
            for (int i = 0; i < steps; i++)
            begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                    txt.push_back(rand_blank());
                if (letters.size() == 0 || r < 35)
                begin
                    txt.push_back(CH_OPEN);
                    letters.push_back(0);
                end
                else if (r < 70 && (letters[letters.size() - 1] < 2 ||
                                    $urandom_range(0, 19) == 0))
                begin
                    txt.push_back(rand_letter());
                    letters[letters.size() - 1] += 1;
                end
                else
                begin
                    txt.push_back(CH_CLOSE);
                    void'(letters.pop_back());
                end
            end
            if (fault == 8)
                txt.insert($urandom_range(0, txt.size()), 8'($urandom_range(0, 255)));
            if (fault != 9)
                repeat (letters.size()) txt.push_back(CH_CLOSE);
            if (fault == 10)
                txt.push_back(CH_CLOSE);
            else if (fault == 11)
                txt.push_back(rand_letter());
        end
        send_bytes(txt, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        while (text_queue.size() != 0 || in_valid || status_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] odd_bytes[$];
        int         send_pct[4];
        int         recv_pct[4];
        int         target;
        send_pct = '{0, 65, 0, 18};
        recv_pct = '{0, 0, 65, 18};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_string("", 1'b0);
        send_string(" \n", 1'b0);
        send_string("(ab)", 1'b1);
        send_string("(AZaz)", 1'b1);
        send_string(")", 1'b1);
        send_string("a", 1'b0);
        send_string("(\377)", 1'b1);
        odd_bytes = '{CH_OPEN, 8'h00, CH_CLOSE};
        send_bytes(odd_bytes, 1'b1);
        send_string("((a)", 1'b1);
        send_string("(a))b", 1'b1);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            target = byte_count + RUN_ITEMS / 4;
            while (byte_count < target)
                gen_tree_text();
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

/* bracket_tree_arity_checker_unit.f */
+incdir+rtl
rtl/btac_pkg.sv
rtl/btac_cell.sv
rtl/btac_ctrl.sv
rtl/bracket_tree_arity_checker_unit.sv
tb/sv/bracket_tree_arity_checker_unit_tb.sv
